>>> sv/mspi_pkg.sv
// Shared types and constants for the metering SPI register slave.
package mspi_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Frame commands and keys.
  localparam logic [7:0]  CMD_READ         = 8'h58;
  localparam logic [7:0]  CMD_WRITE        = 8'hA8;
  localparam logic [23:0] SOFT_RESET_MAGIC = 24'h5A5A5A;
  localparam logic [7:0]  UNLOCK_KEY       = 8'h55;
  localparam logic [9:0]  STATUS_MASK      = 10'h3FF;

  // Register addresses.
  localparam logic [7:0] ADDR_STATUS     = 8'h09;
  localparam logic [7:0] ADDR_RMS_OFFSET = 8'h12;
  localparam logic [7:0] ADDR_CREEP      = 8'h14;
  localparam logic [7:0] ADDR_FAST_THR   = 8'h15;
  localparam logic [7:0] ADDR_FAST_CYC   = 8'h16;
  localparam logic [7:0] ADDR_FREQ_CYC   = 8'h17;
  localparam logic [7:0] ADDR_OUT_SEL    = 8'h18;
  localparam logic [7:0] ADDR_USER_MODE  = 8'h19;
  localparam logic [7:0] ADDR_CUR_GAIN   = 8'h1A;
  localparam logic [7:0] ADDR_SOFT_RESET = 8'h1C;
  localparam logic [7:0] ADDR_UNLOCK     = 8'h1D;

  // Byte slots within a frame.
  localparam logic [2:0] SLOT_CMD  = 3'd0;
  localparam logic [2:0] SLOT_ADDR = 3'd1;
  localparam logic [2:0] SLOT_D2   = 3'd2;
  localparam logic [2:0] SLOT_D1   = 3'd3;
  localparam logic [2:0] SLOT_D0   = 3'd4;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_LOAD,
    OP_RELEASE,
    OP_IDLE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CHECKSUM  = 2'd1,
    ST_BAD_CMD   = 2'd2,
    ST_PROTECTED = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  spi_byte;
    logic [3:0]  meas_index;
    logic [23:0] meas_value;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> sv/mspi_front.sv
// Front end: accepts input transfers and classifies them into queue entries.
module mspi_front
  import mspi_pkg::*;
#(
  parameter int MEAS_SLOTS = 16
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_spi_byte,
  input  logic [3:0]  in_meas_index,
  input  logic [23:0] in_meas_value,
  input  qstat_t      q_stat,
  output logic        q_push,
  output qentry_t     q_entry
);

  logic idx_ok;

  assign idx_ok   = {1'b0, in_meas_index} < 5'(MEAS_SLOTS);
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_entry.spi_byte   = in_spi_byte;
    q_entry.meas_index = in_meas_index;
    q_entry.meas_value = in_meas_value;
    unique case (in_action)
      ACT_BYTE:    q_entry.op = OP_BYTE;
      ACT_LOAD:    q_entry.op = idx_ok ? OP_LOAD : OP_IDLE;
      ACT_RELEASE: q_entry.op = OP_RELEASE;
      default:     q_entry.op = OP_IDLE;
    endcase
  end

endmodule

>>> sv/mspi_queue.sv
// Two-entry queue between the front end and the frame engine.
module mspi_queue
  import mspi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_entry,
  input  logic    pop,
  output qentry_t pop_entry,
  output qstat_t  stat
);

  qentry_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> sv/mspi_back.sv
// Frame engine: register file, frame tracking and the registered result stage.
module mspi_back
  import mspi_pkg::*;
#(
  parameter int MEAS_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  qentry_t    q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_miso_byte,
  output logic       out_frame_end,
  output logic       out_write_done,
  output logic [1:0] out_frame_status
);

  localparam int IDX_W = $clog2(MEAS_SLOTS);

  function automatic logic [2:0] sat7(input logic [23:0] v);
    return (v > 24'd7) ? 3'd7 : v[2:0];
  endfunction

  function automatic logic [1:0] sat3(input logic [23:0] v);
    return (v > 24'd3) ? 2'd3 : v[1:0];
  endfunction

  function automatic logic [5:0] sat63(input logic [23:0] v);
    return (v > 24'd63) ? 6'd63 : v[5:0];
  endfunction

  logic [23:0] meas_r [MEAS_SLOTS];
  logic        meas_we;

  logic [2:0]  pos_r, pos_nxt;
  logic        is_wr_r, is_wr_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [23:0] data_r, data_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic [7:0]  rms_offset_r, rms_offset_nxt;
  logic [7:0]  creep_r, creep_nxt;
  logic [15:0] fast_thr_r, fast_thr_nxt;
  logic [2:0]  fast_cyc_r, fast_cyc_nxt;
  logic [1:0]  freq_cyc_r, freq_cyc_nxt;
  logic [5:0]  out_sel_r, out_sel_nxt;
  logic [9:0]  user_mode_r, user_mode_nxt;
  logic [1:0]  cur_gain_r, cur_gain_nxt;
  logic [7:0]  unlock_r, unlock_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  miso_r, miso_nxt;
  logic        fend_r, fend_nxt;
  logic        wdone_r, wdone_nxt;
  status_t     status_r, status_nxt;

  logic        fire;
  logic [23:0] rd_meas;
  logic [23:0] rd_value;
  logic [23:0] cur_data;
  logic [7:0]  d_byte;
  logic [7:0]  chk;
  logic        in_meas;

  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign in_meas   = addr_r < 8'(MEAS_SLOTS);
  assign rd_meas   = in_meas ? meas_r[addr_r[IDX_W-1:0]] : 24'd0;
  assign chk       = ~sum_r;

  // Read value of the addressed register.
  always_comb begin
    if (in_meas) begin
      rd_value = (addr_r == ADDR_STATUS) ? {14'd0, rd_meas[9:0] & STATUS_MASK} : rd_meas;
    end else begin
      unique case (addr_r)
        ADDR_RMS_OFFSET: rd_value = {16'd0, rms_offset_r};
        ADDR_CREEP:      rd_value = {16'd0, creep_r};
        ADDR_FAST_THR:   rd_value = {8'd0, fast_thr_r};
        ADDR_FAST_CYC:   rd_value = {21'd0, fast_cyc_r};
        ADDR_FREQ_CYC:   rd_value = {22'd0, freq_cyc_r};
        ADDR_OUT_SEL:    rd_value = {18'd0, out_sel_r};
        ADDR_USER_MODE:  rd_value = {14'd0, user_mode_r};
        ADDR_CUR_GAIN:   rd_value = {22'd0, cur_gain_r};
        ADDR_UNLOCK:     rd_value = {16'd0, unlock_r};
        default:         rd_value = 24'd0;
      endcase
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    is_wr_nxt      = is_wr_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    sum_nxt        = sum_r;
    rms_offset_nxt = rms_offset_r;
    creep_nxt      = creep_r;
    fast_thr_nxt   = fast_thr_r;
    fast_cyc_nxt   = fast_cyc_r;
    freq_cyc_nxt   = freq_cyc_r;
    out_sel_nxt    = out_sel_r;
    user_mode_nxt  = user_mode_r;
    cur_gain_nxt   = cur_gain_r;
    unlock_nxt     = unlock_r;
    meas_we        = 1'b0;
    miso_nxt       = 8'd0;
    fend_nxt       = 1'b0;
    wdone_nxt      = 1'b0;
    status_nxt     = ST_OK;
    cur_data       = 24'd0;
    d_byte         = 8'd0;

    if (fire) begin
      unique case (q_entry.op)
        OP_LOAD: meas_we = 1'b1;
        OP_RELEASE: begin
          pos_nxt   = SLOT_CMD;
          is_wr_nxt = 1'b0;
          addr_nxt  = 8'd0;
          data_nxt  = 24'd0;
          sum_nxt   = 8'd0;
        end
        OP_BYTE: begin
          unique case (pos_r)
            SLOT_CMD: begin
              if (q_entry.spi_byte == CMD_READ || q_entry.spi_byte == CMD_WRITE) begin
                is_wr_nxt = q_entry.spi_byte == CMD_WRITE;
                sum_nxt   = q_entry.spi_byte;
                data_nxt  = 24'd0;
                pos_nxt   = SLOT_ADDR;
              end else begin
                status_nxt = ST_BAD_CMD;
              end
            end
            SLOT_ADDR: begin
              addr_nxt = q_entry.spi_byte;
              sum_nxt  = sum_r + q_entry.spi_byte;
              pos_nxt  = SLOT_D2;
            end
            SLOT_D2, SLOT_D1, SLOT_D0: begin
              if (is_wr_r) begin
                data_nxt = {data_r[15:0], q_entry.spi_byte};
                d_byte   = q_entry.spi_byte;
              end else begin
                // Read data is snapshotted at the first data slot.
                cur_data = (pos_r == SLOT_D2) ? rd_value : data_r;
                data_nxt = cur_data;
                unique case (pos_r)
                  SLOT_D2: d_byte = cur_data[23:16];
                  SLOT_D1: d_byte = cur_data[15:8];
                  default: d_byte = cur_data[7:0];
                endcase
                miso_nxt = d_byte;
              end
              sum_nxt = sum_r + d_byte;
              pos_nxt = pos_r + 3'd1;
            end
            default: begin
              fend_nxt = 1'b1;
              if (is_wr_r) begin
                if (q_entry.spi_byte != chk) begin
                  status_nxt = ST_CHECKSUM;
                end else if (unlock_r != UNLOCK_KEY && addr_r != ADDR_UNLOCK) begin
                  status_nxt = ST_PROTECTED;
                end else begin
                  wdone_nxt = 1'b1;
                  unique case (addr_r)
                    ADDR_RMS_OFFSET: rms_offset_nxt = data_r[7:0];
                    ADDR_CREEP:      creep_nxt      = data_r[7:0];
                    ADDR_FAST_THR:   fast_thr_nxt   = data_r[15:0];
                    ADDR_FAST_CYC:   fast_cyc_nxt   = sat7(data_r);
                    ADDR_FREQ_CYC:   freq_cyc_nxt   = sat3(data_r);
                    ADDR_OUT_SEL:    out_sel_nxt    = sat63(data_r);
                    ADDR_USER_MODE:  user_mode_nxt  = data_r[9:0];
                    ADDR_CUR_GAIN:   cur_gain_nxt   = sat3(data_r);
                    ADDR_UNLOCK:     unlock_nxt     = data_r[7:0];
                    ADDR_SOFT_RESET: begin
                      if (data_r == SOFT_RESET_MAGIC) begin
                        rms_offset_nxt = 8'd0;
                        creep_nxt      = 8'd0;
                        fast_thr_nxt   = 16'd0;
                        fast_cyc_nxt   = 3'd0;
                        freq_cyc_nxt   = 2'd0;
                        out_sel_nxt    = 6'd0;
                        user_mode_nxt  = 10'd0;
                        cur_gain_nxt   = 2'd0;
                        unlock_nxt     = 8'd0;
                      end else begin
                        wdone_nxt = 1'b0;
                      end
                    end
                    default: wdone_nxt = 1'b0;
                  endcase
                end
              end else begin
                miso_nxt = chk;
              end
              pos_nxt   = SLOT_CMD;
              is_wr_nxt = 1'b0;
              addr_nxt  = 8'd0;
              data_nxt  = 24'd0;
              sum_nxt   = 8'd0;
            end
          endcase
        end
        default: ;
      endcase
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= SLOT_CMD;
      is_wr_r      <= 1'b0;
      addr_r       <= 8'd0;
      data_r       <= 24'd0;
      sum_r        <= 8'd0;
      rms_offset_r <= 8'd0;
      creep_r      <= 8'd0;
      fast_thr_r   <= 16'd0;
      fast_cyc_r   <= 3'd0;
      freq_cyc_r   <= 2'd0;
      out_sel_r    <= 6'd0;
      user_mode_r  <= 10'd0;
      cur_gain_r   <= 2'd0;
      unlock_r     <= 8'd0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MEAS_SLOTS; i++) begin
        meas_r[i] <= 24'd0;
      end
    end else begin
      pos_r        <= pos_nxt;
      is_wr_r      <= is_wr_nxt;
      addr_r       <= addr_nxt;
      data_r       <= data_nxt;
      sum_r        <= sum_nxt;
      rms_offset_r <= rms_offset_nxt;
      creep_r      <= creep_nxt;
      fast_thr_r   <= fast_thr_nxt;
      fast_cyc_r   <= fast_cyc_nxt;
      freq_cyc_r   <= freq_cyc_nxt;
      out_sel_r    <= out_sel_nxt;
      user_mode_r  <= user_mode_nxt;
      cur_gain_r   <= cur_gain_nxt;
      unlock_r     <= unlock_nxt;
      out_valid_r  <= out_valid_nxt;
      if (meas_we) begin
        meas_r[q_entry.meas_index[IDX_W-1:0]] <= q_entry.meas_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      miso_r   <= miso_nxt;
      fend_r   <= fend_nxt;
      wdone_r  <= wdone_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_miso_byte    = miso_r;
  assign out_frame_end    = fend_r;
  assign out_write_done   = wdone_r;
  assign out_frame_status = status_r;

endmodule

>>> sv/metering_spi_register_slave_top.sv
// An accepted transfer is first written into the queue, and the engine then registers its result.
// Throughput: one transfer per cycle while the output side takes every result.
// A two-entry queue sits between the classifier and the engine, so input keeps flowing
// while a result waits for the output side to take it.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result and clears
// the frame state, the measured registers and all user registers to zero.
module metering_spi_register_slave_top
  import mspi_pkg::*;
#(
  parameter int MEAS_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_spi_byte,
  input  logic [3:0]  in_meas_index,
  input  logic [23:0] in_meas_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_miso_byte,
  output logic        out_frame_end,
  output logic        out_write_done,
  output logic [1:0]  out_frame_status
);

  // Handshake between the front end, the queue and the frame engine.
  qstat_t  q_stat;
  logic    q_push;
  logic    q_pop;
  qentry_t q_in;
  qentry_t q_out;

  // The front end turns each input transfer into an operation code. Loads that
  // address a slot beyond the measured register file become no-ops here, so the
  // engine never sees an out-of-range index.
  mspi_front #(
    .MEAS_SLOTS(MEAS_SLOTS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_spi_byte   (in_spi_byte),
    .in_meas_index (in_meas_index),
    .in_meas_value (in_meas_value),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  // The queue decouples the two sides: the engine can stall on the output
  // without pushing back on the input until both entries are occupied.
  mspi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .stat       (q_stat)
  );

  // The engine pops one operation whenever its result register is free or
  // being drained, updates the frame and register state, and registers the result.
  mspi_back #(
    .MEAS_SLOTS(MEAS_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (!q_stat.empty),
    .q_entry          (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_miso_byte    (out_miso_byte),
    .out_frame_end    (out_frame_end),
    .out_write_done   (out_write_done),
    .out_frame_status (out_frame_status)
  );

  // A register update only happens on a completed, accepted frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_done |-> out_frame_end && out_frame_status == ST_OK)
    else $error("write_done without a clean frame end");

  // A rejected command byte never completes a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_BAD_CMD |-> !out_frame_end)
    else $error("bad command reported on a frame end");

  // The queue can never report full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // The engine only pops what the queue holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

>>> tb/mspi_reply_monitor.sv
// Watches both channels of the metering SPI slave, predicts each result and compares it.
module mspi_reply_monitor
  import mspi_pkg::*;
#(
  parameter int MEAS_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_spi_byte,
  input  logic [3:0]  in_meas_index,
  input  logic [23:0] in_meas_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_miso_byte,
  input  logic        out_frame_end,
  input  logic        out_write_done,
  input  logic [1:0]  out_frame_status,
  output int          fail_count,
  output int          pending_replies
);

  typedef struct packed {
    logic [7:0] miso;
    logic       fend;
    logic       wdone;
    status_t    status;
  } reply_t;

  reply_t expected_replies[$];
  reply_t want;

  // Frame state.
  logic [2:0]  slot;
  logic        is_write;
  logic [7:0]  addr;
  logic [23:0] data;
  logic [7:0]  sum;

  // Register file.
  logic [23:0] meas [MEAS_SLOTS];
  logic [7:0]  rms_offset;
  logic [7:0]  creep_level;
  logic [15:0] fast_thr;
  logic [2:0]  fast_cyc;
  logic [1:0]  freq_cyc;
  logic [5:0]  out_sel;
  logic [9:0]  user_mode;
  logic [1:0]  cur_gain;
  logic [7:0]  unlock;

  function automatic void clear_frame();
    slot = SLOT_CMD;
    is_write = 1'b0;
    addr = '0;
    data = '0;
    sum = '0;
  endfunction

  function automatic void clear_user_regs();
    rms_offset = '0;
    creep_level = '0;
    fast_thr = '0;
    fast_cyc = '0;
    freq_cyc = '0;
    out_sel = '0;
    user_mode = '0;
    cur_gain = '0;
    unlock = '0;
  endfunction

  function automatic logic [23:0] clamp(input logic [23:0] v, input logic [23:0] top);
    return (v > top) ? top : v;
  endfunction

  function automatic logic [23:0] reg_value(input logic [7:0] a);
    logic [23:0] v;
    v = '0;
    if (a < MEAS_SLOTS) begin
      v = meas[a];
      if (a == ADDR_STATUS) v = v & {14'd0, STATUS_MASK};
    end else begin
      case (a)
        ADDR_RMS_OFFSET: v = {16'd0, rms_offset};
        ADDR_CREEP:      v = {16'd0, creep_level};
        ADDR_FAST_THR:   v = {8'd0, fast_thr};
        ADDR_FAST_CYC:   v = {21'd0, fast_cyc};
        ADDR_FREQ_CYC:   v = {22'd0, freq_cyc};
        ADDR_OUT_SEL:    v = {18'd0, out_sel};
        ADDR_USER_MODE:  v = {14'd0, user_mode};
        ADDR_CUR_GAIN:   v = {22'd0, cur_gain};
        ADDR_UNLOCK:     v = {16'd0, unlock};
        default:         v = '0;
      endcase
    end
    return v;
  endfunction

  // Returns 1 when the write changed register state.
  function automatic logic apply_write(input logic [7:0] a, input logic [23:0] v);
    case (a)
      ADDR_RMS_OFFSET: begin rms_offset = v[7:0]; return 1'b1; end
      ADDR_CREEP:      begin creep_level = v[7:0]; return 1'b1; end
      ADDR_FAST_THR:   begin fast_thr = v[15:0]; return 1'b1; end
      ADDR_FAST_CYC:   begin fast_cyc = 3'(clamp(v, 24'd7)); return 1'b1; end
      ADDR_FREQ_CYC:   begin freq_cyc = 2'(clamp(v, 24'd3)); return 1'b1; end
      ADDR_OUT_SEL:    begin out_sel = 6'(clamp(v, 24'd63)); return 1'b1; end
      ADDR_USER_MODE:  begin user_mode = v[9:0]; return 1'b1; end
      ADDR_CUR_GAIN:   begin cur_gain = 2'(clamp(v, 24'd3)); return 1'b1; end
      ADDR_UNLOCK:     begin unlock = v[7:0]; return 1'b1; end
      ADDR_SOFT_RESET: begin
        if (v == SOFT_RESET_MAGIC) begin
          clear_user_regs();
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic reply_t step_frame(input op_t op, input logic [7:0] b,
                                        input logic [3:0] idx, input logic [23:0] val);
    reply_t r;
    logic [7:0] d;
    logic [7:0] chk;
    r = '{miso: 8'h00, fend: 1'b0, wdone: 1'b0, status: ST_OK};
    case (op)
      OP_LOAD: if (idx < MEAS_SLOTS) meas[idx] = val;
      OP_RELEASE: clear_frame();
      OP_BYTE: begin
        case (slot)
          SLOT_CMD: begin
            if (b == CMD_READ || b == CMD_WRITE) begin
              is_write = (b == CMD_WRITE);
              sum = b;
              data = '0;
              slot = SLOT_ADDR;
            end else begin
              r.status = ST_BAD_CMD;
            end
          end
          SLOT_ADDR: begin
            addr = b;
            sum = sum + b;
            slot = SLOT_D2;
          end
          SLOT_D2, SLOT_D1, SLOT_D0: begin
            if (is_write) begin
              data = {data[15:0], b};
              d = b;
            end else begin
              // Read data is snapshotted when the first data slot goes out.
              if (slot == SLOT_D2) data = reg_value(addr);
              d = 8'(data >> (8 * (SLOT_D0 - slot)));
              r.miso = d;
            end
            sum = sum + d;
            slot = slot + 3'd1;
          end
          default: begin
            chk = ~sum;
            r.fend = 1'b1;
            if (!is_write) begin
              r.miso = chk;
            end else if (b != chk) begin
              r.status = ST_CHECKSUM;
            end else if (unlock != UNLOCK_KEY && addr != ADDR_UNLOCK) begin
              r.status = ST_PROTECTED;
            end else begin
              r.wdone = apply_write(addr, data);
            end
            clear_frame();
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      clear_user_regs();
      foreach (meas[i]) meas[i] = '0;
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        expected_replies.push_back(step_frame(op_t'(in_action), in_spi_byte,
                                              in_meas_index, in_meas_value));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no expected result: miso_byte %0h", out_miso_byte);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_miso_byte !== want.miso) begin
            $error("miso_byte: expected %0h, got %0h", want.miso, out_miso_byte);
            fail_count++;
          end
          if (out_frame_end !== want.fend) begin
            $error("frame_end: expected %0d, got %0d", want.fend, out_frame_end);
            fail_count++;
          end
          if (out_write_done !== want.wdone) begin
            $error("write_done: expected %0d, got %0d", want.wdone, out_write_done);
            fail_count++;
          end
          if (out_frame_status !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, out_frame_status);
            fail_count++;
          end
        end
      end
    end
    pending_replies = expected_replies.size();
  end

endmodule

>>> tb/metering_spi_register_slave_top_tb.sv
// Testbench top for the metering SPI register slave: stimulus, flow control and verdict.
module metering_spi_register_slave_top_tb;
  import mspi_pkg::*;

  localparam int TARGET_TRANSFERS = 1800;
  // The receiver stops taking results for a long stretch once this many inputs went in.
  localparam int HOLD_AT          = 400;
  localparam int HOLD_CYCLES      = 300;
  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT   = 5000;
  // Settling time after the last expected result.
  localparam int DRAIN_CYCLES     = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_spi_byte;
  logic [3:0]  in_meas_index;
  logic [23:0] in_meas_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_miso_byte;
  logic        out_frame_end;
  logic        out_write_done;
  logic [1:0]  out_frame_status;

  int fail_count;
  int pending_replies;
  int transfers_done;
  int idle_cycles;
  // When set, no side adds random gaps; the block runs at full rate outside the long hold.
  bit no_gaps;

  metering_spi_register_slave_top #(
    .MEAS_SLOTS(16)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_spi_byte      (in_spi_byte),
    .in_meas_index    (in_meas_index),
    .in_meas_value    (in_meas_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_miso_byte    (out_miso_byte),
    .out_frame_end    (out_frame_end),
    .out_write_done   (out_write_done),
    .out_frame_status (out_frame_status)
  );

  mspi_reply_monitor #(
    .MEAS_SLOTS(16)
  ) u_reply_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_spi_byte      (in_spi_byte),
    .in_meas_index    (in_meas_index),
    .in_meas_value    (in_meas_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_miso_byte    (out_miso_byte),
    .out_frame_end    (out_frame_end),
    .out_write_done   (out_write_done),
    .out_frame_status (out_frame_status),
    .fail_count       (fail_count),
    .pending_replies  (pending_replies)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back-to-back transfers, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one input transfer and returns once it has been accepted. The payload stays
  // fixed and valid stays high while the block stalls.
  task automatic offer(input op_t op, input logic [7:0] b, input logic [3:0] idx,
                       input logic [23:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= op;
    in_spi_byte   <= b;
    in_meas_index <= idx;
    in_meas_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Action 3 is ignored by the block, so it does not count toward the item budget.
    if (op != OP_IDLE) transfers_done++;
  endtask

  // The fields that an action does not use carry random junk, which must be ignored.
  task automatic send_byte(input logic [7:0] b);
    offer(OP_BYTE, b, 4'($urandom), 24'($urandom));
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [23:0] val);
    offer(OP_LOAD, 8'($urandom), idx, val);
  endtask

  task automatic send_release();
    offer(OP_RELEASE, 8'($urandom), 4'($urandom), 24'($urandom));
  endtask

  function automatic logic [7:0] good_checksum(input logic [7:0] cmd, input logic [7:0] a,
                                               input logic [23:0] d);
    logic [7:0] s;
    s = cmd + a + d[23:16] + d[15:8] + d[7:0];
    return ~s;
  endfunction

  // Sends a six-byte frame. Chip select is released just before byte cut_at (no release
  // when cut_at is 6 or more). With mix set, measured-register loads may be slipped in
  // between bytes, which must not disturb the frame.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] a, input logic [23:0] d,
                            input logic [7:0] chk, input int cut_at, input bit mix);
    logic [7:0] seq [6];
    seq[0] = cmd;
    seq[1] = a;
    seq[2] = d[23:16];
    seq[3] = d[15:8];
    seq[4] = d[7:0];
    seq[5] = chk;
    for (int i = 0; i < 6; i++) begin
      if (i == cut_at) begin
        send_release();
        return;
      end
      if (mix && $urandom_range(19) == 0) send_load(4'($urandom), 24'($urandom));
      send_byte(seq[i]);
    end
  endtask

  // Addresses for random frames: mostly the named registers, then measured slots, then
  // any byte at all.
  function automatic logic [7:0] pick_address(input bit for_write);
    int r;
    r = $urandom_range(99);
    if (for_write && r < 20) return ADDR_UNLOCK;
    if (r < 70) begin
      case ($urandom_range(10))
        0:       return ADDR_RMS_OFFSET;
        1:       return ADDR_CREEP;
        2:       return ADDR_FAST_THR;
        3:       return ADDR_FAST_CYC;
        4:       return ADDR_FREQ_CYC;
        5:       return ADDR_OUT_SEL;
        6:       return ADDR_USER_MODE;
        7:       return ADDR_CUR_GAIN;
        8:       return ADDR_SOFT_RESET;
        9:       return ADDR_UNLOCK;
        default: return ADDR_STATUS;
      endcase
    end
    if (r < 85) return 8'($urandom_range(15));
    return 8'($urandom);
  endfunction

  // Write data leans toward the keys and the saturation edges so that unlocks, soft resets
  // and clamping all happen often.
  function automatic logic [23:0] pick_write_data(input logic [7:0] a);
    int r;
    r = $urandom_range(99);
    if (a == ADDR_SOFT_RESET && r < 50) return SOFT_RESET_MAGIC;
    if (a == ADDR_UNLOCK && r < 70) return {16'd0, UNLOCK_KEY};
    r = $urandom_range(99);
    if (r < 15) return 24'h000000;
    if (r < 30) return 24'hFFFFFF;
    if (r < 60) return 24'($urandom_range(0, 80));
    return 24'($urandom);
  endfunction

  task automatic random_frame();
    logic [7:0]  a;
    logic [23:0] d;
    logic [7:0]  chk;
    bit          wr;
    int          cut_at;
    wr = $urandom_range(1);
    a = pick_address(wr);
    cut_at = ($urandom_range(19) == 0) ? $urandom_range(1, 5) : 6;
    if (wr) begin
      d = pick_write_data(a);
      chk = good_checksum(CMD_WRITE, a, d);
      // A corrupted checksum now and then; the XOR keeps it from matching by accident.
      if ($urandom_range(99) < 15) chk = chk ^ 8'($urandom_range(1, 255));
      send_frame(CMD_WRITE, a, d, chk, cut_at, 1'b1);
    end else begin
      // The host's data and checksum bytes in a read are don't-care.
      send_frame(CMD_READ, a, 24'($urandom), 8'($urandom), cut_at, 1'b1);
    end
  endtask

  task automatic random_load();
    logic [23:0] val;
    case ($urandom_range(3))
      0:       val = 24'h000000;
      1:       val = 24'hFFFFFF;
      default: val = 24'($urandom);
    endcase
    send_load(4'($urandom), val);
  endtask

  // Receiver side. It stalls in random bursts and, once, holds off for a long stretch
  // while the sender keeps offering, which fills the block and stalls its input.
  initial begin : result_sink
    int  stall;
    int  r;
    bit  held;
    stall = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && transfers_done >= HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 75) begin
          out_ready <= 1'b1;
        end else begin
          stall = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("metering_spi_register_slave_top test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int next_switch;
    int r;
    transfers_done = 0;
    no_gaps = 1'b0;
    next_switch = 150;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= OP_BYTE;
    in_spi_byte   <= '0;
    in_meas_index <= '0;
    in_meas_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // A byte that is not a command is dropped and reported as a bad command.
    send_byte(8'hFF);
    // The unused action changes nothing and gives an all-zero result.
    offer(OP_IDLE, 8'h00, 4'hF, 24'hFFFFFF);
    // The status register reads back only its low ten bits.
    send_load(ADDR_STATUS[3:0], 24'hFFFFFF);
    send_frame(CMD_READ, ADDR_STATUS, 24'h000000, 8'h00, 6, 1'b0);
    // Registers start locked, so this well-formed write is refused.
    send_frame(CMD_WRITE, ADDR_RMS_OFFSET, 24'hFFFFFF,
               good_checksum(CMD_WRITE, ADDR_RMS_OFFSET, 24'hFFFFFF), 6, 1'b0);
    // The write-protect register itself can always be written.
    send_frame(CMD_WRITE, ADDR_UNLOCK, {16'd0, UNLOCK_KEY},
               good_checksum(CMD_WRITE, ADDR_UNLOCK, {16'd0, UNLOCK_KEY}), 6, 1'b0);
    // Releasing chip select mid-frame abandons it.
    send_frame(CMD_WRITE, 8'h00, 24'h000000, 8'h00, 1, 1'b0);

    // Random part: mostly well-formed frames with random content, the rest noise.
    while (transfers_done < TARGET_TRANSFERS) begin
      if (transfers_done >= next_switch) begin
        next_switch = transfers_done + 150;
        no_gaps = ($urandom_range(3) == 0);
      end
      r = $urandom_range(99);
      if (r < 70)      random_frame();
      else if (r < 85) random_load();
      else if (r < 90) send_release();
      else if (r < 94) offer(OP_IDLE, 8'($urandom), 4'($urandom), 24'($urandom));
      else             send_byte(8'($urandom));
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then let the pipeline settle.
    do @(posedge clk); while (pending_replies != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_replies == 0)
      $display("metering_spi_register_slave_top test passed");
    else
      $display("metering_spi_register_slave_top test failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/mspi_pkg.sv
sv/mspi_front.sv
sv/mspi_queue.sv
sv/mspi_back.sv
sv/metering_spi_register_slave_top.sv
tb/mspi_reply_monitor.sv
tb/metering_spi_register_slave_top_tb.sv
